@@ rtl/core/ansi_text_console_engine_top_defines.svh @@
// Assertion macros for the text console engine.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ANSI_TEXT_CONSOLE_ENGINE_TOP_DEFINES_SVH
`define ANSI_TEXT_CONSOLE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, reset masks the check
`define ATCE_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check
`define ATCE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/atce_pkg.sv @@
// Shared types, constants and helper functions of the text console engine.
// No dependencies; imported by every module of the block except atce_ram.
package atce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int CELL_W  = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;

  // control and sequence bytes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // CSI final bytes
  localparam logic [7:0] FN_CUU = 8'h41;
  localparam logic [7:0] FN_CUD = 8'h42;
  localparam logic [7:0] FN_CUF = 8'h43;
  localparam logic [7:0] FN_CUB = 8'h44;
  localparam logic [7:0] FN_CNL = 8'h45;
  localparam logic [7:0] FN_CPL = 8'h46;
  localparam logic [7:0] FN_CHA = 8'h47;
  localparam logic [7:0] FN_CUP = 8'h48;
  localparam logic [7:0] FN_ED  = 8'h4A;
  localparam logic [7:0] FN_EL  = 8'h4B;
  localparam logic [7:0] FN_SU  = 8'h53;
  localparam logic [7:0] FN_SD  = 8'h54;
  localparam logic [7:0] FN_HVP = 8'h66;
  localparam logic [7:0] FN_SGR = 8'h6D;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_PARAM  = 2'd2;
  localparam logic [1:0] PH_INTER  = 2'd3;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_WAIT, ST_CP_RD, ST_CP_WR, ST_FILL, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_READ, ACT_WRITE, ACT_FILL, ACT_SCUP, ACT_SCDN
  } act_t;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        char_byte;
    logic [CELL_W-1:0] read_index;
    logic              read_ok;
  } item_t;

  typedef struct packed {
    logic busy;
    logic init_clear;
  } back_status_t;

  function automatic logic [3:0] ansi_vga(input logic [2:0] c);
    logic [3:0] v;
    case (c)
      3'd0: v = 4'd0;
      3'd1: v = 4'd4;
      3'd2: v = 4'd2;
      3'd3: v = 4'd6;
      3'd4: v = 4'd1;
      3'd5: v = 4'd5;
      3'd6: v = 4'd3;
      default: v = 4'd7;
    endcase
    return v;
  endfunction

  // Apply one SGR code to an attribute
  function automatic logic [7:0] sgr_apply(input logic [16:0] code, input logic [7:0] cur,
                                           input logic [7:0] dflt);
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [16:0] d30;
    logic [16:0] d40;
    logic [16:0] d90;
    logic [16:0] d100;
    fg   = cur[3:0];
    bg   = cur[7:4];
    d30  = code - 17'd30;
    d40  = code - 17'd40;
    d90  = code - 17'd90;
    d100 = code - 17'd100;
    if (code >= 17'd30 && code <= 17'd37) fg = ansi_vga(d30[2:0]);
    else if (code == 17'd39) fg = dflt[3:0];
    else if (code >= 17'd40 && code <= 17'd47) bg = ansi_vga(d40[2:0]);
    else if (code == 17'd49) bg = dflt[7:4];
    else if (code >= 17'd90 && code <= 17'd97) fg = ansi_vga(d90[2:0]) + 4'd8;
    else if (code >= 17'd100 && code <= 17'd107) bg = ansi_vga(d100[2:0]) + 4'd8;
    return {bg, fg};
  endfunction

endpackage

@@ rtl/core/ansi_text_console_engine_top.sv @@
// Text console engine: 80x25 character screen with an ANSI escape parser.
// Channels: in_* carries requests; in_tuser[0] is 0 for a character byte,
//   1 for a cell read. out_* returns one result per request. cfg_* loads
//   the default attribute.
// Timing: a character that touches at most one cell goes from the queue
//   through ST_OUT to the output register; a read also passes ST_RD_WAIT
//   (the screen memory read is registered). An erase walks its range at
//   one cell a cycle; a scroll copies each cell in a read state and a
//   write state, then blanks the freed rows at one a cycle (a print or
//   line feed at the bottom adds a one-line scroll).
// Throughput: one request at a time; a two-deep queue keeps taking
//   requests while the engine works.
// Reset: clears the screen to spaces in attribute 7, with in_tready low
//   meanwhile. A cfg write taken while idle clears likewise with the new value.
// Stall: the result holds in the output register while out_tready is low;
//   the next result waits behind it, the queue fills, then in_tready drops.
// Depends on atce_pkg, atce_front, atce_back and the defines header.
`include "ansi_text_console_engine_top_defines.svh"

module ansi_text_console_engine_top
  import atce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_byte[7:0], read_index[18:8], zero pad
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // cell_entry[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], current_attribute[35:28],
                                  // parse_phase[37:36], zero pad
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic         q_valid;
  item_t        q_item;
  logic         q_pop;
  back_status_t st;

  atce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .st        (st),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  atce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .st          (st),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // cursor in a result always lies on the screen
  `ATCE_CHECK(a_row_range, out_tvalid, out_tdata[20:16] < 5'(ROWS), "cursor row off screen")
  `ATCE_CHECK(a_col_range, out_tvalid, out_tdata[27:21] < 7'(COLUMNS), "cursor col off screen")
  // a dequeued request always makes the engine busy
  `ATCE_CHECK_NEXT(a_pop_busy, q_pop, st.busy, "engine idle after dequeue")

endmodule

@@ rtl/core/atce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/atce_front.sv @@
// Front end: takes requests, flags read addresses in range, queues two deep.
// Depends on atce_pkg.
module atce_front
  import atce_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,
  input  logic [0:0]   in_tuser,
  input  back_status_t st,
  output logic         q_valid,
  output item_t        q_item,
  input  logic         q_pop
);

  item_t      mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      item_in;

  // classify the incoming request
  always_comb begin
    item_in.req_type   = in_tuser[0];
    item_in.char_byte  = in_tdata[7:0];
    item_in.read_index = in_tdata[18:8];
    item_in.read_ok    = (in_tdata[18:8] < CELL_W'(CELLS));
  end

  assign in_tready = (cnt_r != 2'd2) && !st.init_clear;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rptr_r];

  // hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item_in;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ rtl/core/atce_back.sv @@
// Back end: parser, cursor state, screen memory sequencer and result register.
// Depends on atce_pkg and atce_ram.
module atce_back
  import atce_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  output back_status_t st,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata
);

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [7:0]        attr_r, dflt_r;
  logic [1:0]        phase_r;
  logic [15:0]       arg0_r, arg1_r;
  logic [1:0]        slot_r;
  logic [CELL_W-1:0] ptr_r, hi_r, off_r, fill_lo_r, fill_hi_r;
  logic              up_r, post_r, emit_r, rd_ok_r;
  logic [15:0]       cell_r;
  logic              out_valid_r;
  logic [39:0]       out_data_r;

  // decoded request
  logic [ROW_W-1:0]  d_row;
  logic [COL_W-1:0]  d_col;
  logic [7:0]        d_attr;
  logic [1:0]        d_phase;
  logic [15:0]       d_arg0, d_arg1;
  logic [1:0]        d_slot;
  act_t              d_act;
  logic [CELL_W-1:0] d_addr, d_lo, d_hi, d_off;
  logic [15:0]       d_data;
  logic              d_post;

  logic [CELL_W-1:0] here, line;
  logic [15:0]       blank;
  logic [15:0]       n, m;
  logic [7:0]        c;
  logic [ROW_W+1:0]  rowx;
  logic [COL_W:0]    colx;
  logic [10:0]       vt_prod;
  logic [16:0]       rsum, csum, p1e;
  logic [19:0]       acc;
  logic [15:0]       acc_in;
  logic [7:0]        sgr_a;

  // RAM port
  logic              wr_en, rd_en;
  logic [CELL_W-1:0] wr_addr, rd_addr;
  logic [15:0]       wr_data, rd_data;

  logic copy_done, fill_done, out_load;

  assign here  = CELL_W'(row_r) * CELL_W'(COLUMNS) + CELL_W'(col_r);
  assign line  = CELL_W'(row_r) * CELL_W'(COLUMNS);
  assign blank = {attr_r, CH_SPACE};
  assign n     = (arg0_r == 16'd0) ? 16'd1 : arg0_r;
  assign m     = (arg1_r == 16'd0) ? 16'd1 : arg1_r;
  assign c     = q_item.char_byte;

  assign q_pop = (state_r == ST_IDLE) && q_valid && !cfg_wr_en;

  // decode one request against the current state
  always_comb begin
    d_phase = phase_r;
    d_attr  = attr_r;
    d_arg0  = arg0_r;
    d_arg1  = arg1_r;
    d_slot  = slot_r;
    d_act   = ACT_NONE;
    d_addr  = here;
    d_data  = blank;
    d_lo    = '0;
    d_hi    = CELL_W'(CELLS);
    d_off   = CELL_W'(COLUMNS);
    d_post  = 1'b0;
    rowx    = {2'b00, row_r};
    colx    = {1'b0, col_r};
    vt_prod = 11'(row_r) * 11'd43;
    rsum    = 17'(row_r) + 17'(n);
    csum    = 17'(col_r) + 17'(n);
    acc_in  = (slot_r == 2'd0) ? arg0_r : arg1_r;
    acc     = 20'(acc_in) * 20'd10 + 20'(c - 8'h30);
    p1e     = 17'(arg1_r);
    sgr_a   = attr_r;
    if (q_item.req_type == REQ_READ) begin
      d_act = ACT_READ;
    end else begin
      unique case (phase_r)
        PH_NORMAL: begin
          case (c)
            CH_NUL, CH_BEL: ;
            CH_BS: begin
              if (col_r != '0) begin
                colx   = colx - 8'd1;
                d_act  = ACT_WRITE;
                d_addr = here - CELL_W'(1);
              end
            end
            CH_TAB: colx = {({1'b0, col_r[6:3]} + 5'd1), 3'b000};
            CH_LF: begin
              colx = '0;
              rowx = rowx + 7'd1;
            end
            CH_VT: rowx = (7'(vt_prod[10:8]) + 7'd1) * 7'd6;
            CH_FF: begin
              d_act = ACT_FILL;
              rowx  = '0;
              colx  = '0;
            end
            CH_CR:  colx = '0;
            CH_ESC: d_phase = PH_ESC;
            CH_DEL: d_act = ACT_WRITE;
            default: begin
              d_act  = ACT_WRITE;
              d_data = {attr_r, c};
              colx   = colx + 8'd1;
            end
          endcase
        end
        PH_ESC: begin
          if (c == CH_LBR) begin
            d_arg0  = '0;
            d_arg1  = '0;
            d_slot  = '0;
            d_phase = PH_PARAM;
          end else if (c < 8'h20 || c > 8'h2F) begin
            d_phase = PH_NORMAL;
          end
        end
        PH_PARAM: begin
          if (c >= 8'h20 && c <= 8'h2F) begin
            d_phase = PH_INTER;
          end else if (c >= 8'h30 && c <= 8'h39) begin
            if (slot_r == 2'd0) d_arg0 = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
            else if (slot_r == 2'd1) d_arg1 = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
          end else if (c == CH_SEMI) begin
            if (slot_r >= 2'd1) begin
              d_slot  = 2'd2;
              d_phase = PH_NORMAL;
            end else begin
              d_slot = slot_r + 2'd1;
            end
          end else if (c == CH_COLON || (c >= 8'h3C && c <= 8'h3F)) begin
          end else begin
            d_phase = PH_NORMAL;
            case (c)
              FN_CPL, FN_CUU: begin
                if (c == FN_CPL) colx = '0;
                rowx = (16'(row_r) > n) ? 7'(16'(row_r) - n) : '0;
              end
              FN_CNL, FN_CUD: begin
                if (c == FN_CNL) colx = '0;
                rowx = (rsum < 17'(ROWS)) ? 7'(rsum) : 7'(ROWS - 1);
              end
              FN_CUF: colx = (csum < 17'(COLUMNS)) ? 8'(csum) : 8'(COLUMNS - 1);
              FN_CUB: colx = (16'(col_r) > n) ? 8'(16'(col_r) - n) : '0;
              FN_CHA: colx = (n <= 16'(COLUMNS)) ? 8'(n - 16'd1) : 8'(COLUMNS - 1);
              FN_CUP, FN_HVP: begin
                rowx = (n <= 16'(ROWS)) ? 7'(n - 16'd1) : 7'(ROWS - 1);
                colx = (m <= 16'(COLUMNS)) ? 8'(m - 16'd1) : 8'(COLUMNS - 1);
              end
              FN_ED: begin
                if (arg0_r == 16'd0) begin
                  d_act = ACT_FILL;
                  d_lo  = here;
                end else if (arg0_r == 16'd1) begin
                  d_act = ACT_FILL;
                  d_hi  = here + CELL_W'(1);
                end else if (arg0_r == 16'd2) begin
                  d_act = ACT_FILL;
                end
              end
              FN_EL: begin
                if (arg0_r == 16'd0) begin
                  d_act = ACT_FILL;
                  d_lo  = here;
                  d_hi  = line + CELL_W'(COLUMNS);
                end else if (arg0_r == 16'd1) begin
                  d_act = ACT_FILL;
                  d_lo  = line;
                  d_hi  = here + CELL_W'(1);
                end else if (arg0_r == 16'd2) begin
                  d_act = ACT_FILL;
                  d_lo  = line;
                  d_hi  = line + CELL_W'(COLUMNS);
                end
              end
              FN_SU, FN_SD: begin
                d_off = CELL_W'(n[ROW_W-1:0]) * CELL_W'(COLUMNS);
                if (n >= 16'(ROWS)) d_act = ACT_FILL;
                else if (c == FN_SU) d_act = ACT_SCUP;
                else d_act = ACT_SCDN;
              end
              FN_SGR: begin
                if (arg0_r == 16'd0) sgr_a = dflt_r;
                else if (arg0_r == 16'd1) p1e = 17'(arg1_r) + 17'd60;
                else sgr_a = sgr_apply(17'(arg0_r), attr_r, dflt_r);
                d_attr = sgr_apply(p1e, sgr_a, dflt_r);
              end
              default: ;
            endcase
          end
        end
        default: begin
          if (c < 8'h20 || c > 8'h2F) d_phase = PH_NORMAL;
        end
      endcase
    end
    // wrap at line end, scroll at the bottom
    if (colx >= 8'(COLUMNS)) begin
      colx = '0;
      rowx = rowx + 7'd1;
    end
    if (rowx >= 7'(ROWS)) begin
      colx   = '0;
      rowx   = 7'(ROWS - 1);
      d_post = 1'b1;
    end
    d_row = rowx[ROW_W-1:0];
    d_col = colx[COL_W-1:0];
  end

  assign copy_done = up_r ? (ptr_r + off_r == CELL_W'(CELLS - 1)) : (ptr_r == off_r);
  assign fill_done = (ptr_r + CELL_W'(1) == hi_r);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          state_nxt = ST_FILL;
        end else if (q_valid) begin
          case (d_act)
            ACT_READ:           state_nxt = ST_RD_WAIT;
            ACT_FILL:           state_nxt = ST_FILL;
            ACT_SCUP, ACT_SCDN: state_nxt = ST_CP_RD;
            default:            state_nxt = d_post ? ST_CP_RD : ST_OUT;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_OUT;
      ST_CP_RD:   state_nxt = ST_CP_WR;
      ST_CP_WR:   state_nxt = copy_done ? ST_FILL : ST_CP_RD;
      ST_FILL: begin
        if (fill_done) begin
          if (post_r) state_nxt = ST_CP_RD;
          else state_nxt = emit_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT:  state_nxt = out_load ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = blank;
    rd_en   = 1'b0;
    rd_addr = up_r ? ptr_r + off_r : ptr_r - off_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && d_act == ACT_READ) begin
          rd_en   = 1'b1;
          rd_addr = q_item.read_index;
        end
        if (q_pop && d_act == ACT_WRITE) begin
          wr_en   = 1'b1;
          wr_addr = d_addr;
          wr_data = d_data;
        end
      end
      ST_CP_RD: rd_en = 1'b1;
      ST_CP_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      ST_FILL: wr_en = 1'b1;
      default: ;
    endcase
  end

  atce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state and sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= 8'd7;
      dflt_r      <= 8'd7;
      phase_r     <= PH_NORMAL;
      arg0_r      <= '0;
      arg1_r      <= '0;
      slot_r      <= '0;
      ptr_r       <= '0;
      hi_r        <= CELL_W'(CELLS);
      post_r      <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en) begin
            dflt_r  <= cfg_wr_data;
            attr_r  <= cfg_wr_data;
            row_r   <= '0;
            col_r   <= '0;
            phase_r <= PH_NORMAL;
            arg0_r  <= '0;
            arg1_r  <= '0;
            slot_r  <= '0;
            ptr_r   <= '0;
            hi_r    <= CELL_W'(CELLS);
            emit_r  <= 1'b0;
            post_r  <= 1'b0;
          end else if (q_valid) begin
            row_r   <= d_row;
            col_r   <= d_col;
            attr_r  <= d_attr;
            phase_r <= d_phase;
            arg0_r  <= d_arg0;
            arg1_r  <= d_arg1;
            slot_r  <= d_slot;
            emit_r  <= 1'b1;
            post_r  <= 1'b0;
            case (d_act)
              ACT_FILL: begin
                ptr_r <= d_lo;
                hi_r  <= d_hi;
              end
              ACT_SCUP: ptr_r <= '0;
              ACT_SCDN: ptr_r <= CELL_W'(CELLS - 1);
              default: begin
                if (d_post) begin
                  ptr_r <= '0;
                end
              end
            endcase
          end
        end
        ST_CP_WR: begin
          if (copy_done) begin
            ptr_r <= fill_lo_r;
            hi_r  <= fill_hi_r;
          end else begin
            ptr_r <= up_r ? ptr_r + CELL_W'(1) : ptr_r - CELL_W'(1);
          end
        end
        ST_FILL: begin
          if (fill_done && post_r) begin
            ptr_r  <= '0;
            post_r <= 1'b0;
          end else begin
            ptr_r <= ptr_r + CELL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // scroll setup, read capture and result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_pop) begin
      rd_ok_r <= q_item.read_ok;
      cell_r  <= '0;
      case (d_act)
        ACT_SCUP: begin
          off_r     <= d_off;
          up_r      <= 1'b1;
          fill_lo_r <= CELL_W'(CELLS) - d_off;
          fill_hi_r <= CELL_W'(CELLS);
        end
        ACT_SCDN: begin
          off_r     <= d_off;
          up_r      <= 1'b0;
          fill_lo_r <= '0;
          fill_hi_r <= d_off;
        end
        ACT_FILL, ACT_READ: ;
        default: begin
          off_r     <= CELL_W'(COLUMNS);
          up_r      <= 1'b1;
          fill_lo_r <= CELL_W'(CELLS - COLUMNS);
          fill_hi_r <= CELL_W'(CELLS);
        end
      endcase
    end
    if (state_r == ST_FILL && fill_done && post_r) begin
      off_r     <= CELL_W'(COLUMNS);
      up_r      <= 1'b1;
      fill_lo_r <= CELL_W'(CELLS - COLUMNS);
      fill_hi_r <= CELL_W'(CELLS);
    end
    if (state_r == ST_RD_WAIT) begin
      cell_r <= rd_ok_r ? rd_data : 16'd0;
    end
    if (out_load) begin
      out_data_r <= {2'b00, phase_r, attr_r, col_r, row_r, cell_r};
    end
  end

  assign st.busy       = (state_r != ST_IDLE);
  assign st.init_clear = (state_r == ST_FILL) && !emit_r;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule
